/* rtl/stbs_pkg.sv */
package stbs_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 10;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_STEP,
    ST_FINAL,
    ST_DONE
  } stbs_state_t;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic step;
    logic fin;
    logic clr_res;
    logic out_load;
  } stbs_cmd_t;

  typedef struct packed {
    logic more;
    logic lo_nz;
  } stbs_status_t;

endpackage

/* rtl/stbs_ram.sv */
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/stbs_datapath.sv */
module stbs_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  stbs_pkg::stbs_cmd_t             cmd,
  output stbs_pkg::stbs_status_t          status,
  input  logic [stbs_pkg::COUNT_W-1:0]    entry_count,
  input  logic [stbs_pkg::INDEX_W-1:0]    entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] item_value,
  output logic                            found,
  output logic [stbs_pkg::POS_W-1:0]      position
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned BW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (BW > COUNT_W) ? BW : COUNT_W;
  localparam int unsigned RW = 17;

  logic [BW-1:0]             lo;
  logic [BW-1:0]             hb;
  logic signed [VALUE_W-1:0] key;
  logic                      res_found;
  logic [POS_W-1:0]          res_pos;

  logic [CW-1:0]             count_ext;
  logic [BW-1:0]             n_sat;
  logic                      in_range;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic signed [VALUE_W-1:0] rdata;
  logic [BW:0]               sum_r;
  logic [BW-1:0]             mid_r;
  logic                      go_left;
  logic [BW-1:0]             lo_c;
  logic [BW-1:0]             hb_c;
  logic [BW:0]               sum_c;
  logic [BW-1:0]             mid_c;
  logic                      hit;

  assign count_ext = CW'(entry_count);
  assign n_sat     = (count_ext > CW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(count_ext);
  assign in_range  = RW'(entry_index) < RW'(TABLE_DEPTH);
  assign we        = cmd.wr_en && in_range;
  assign waddr     = AW'(entry_index);

  // mid of the range whose read is now in rdata
  assign sum_r   = (BW + 1)'(lo) + (BW + 1)'(hb) - (BW + 1)'(1);
  assign mid_r   = BW'(sum_r >> 1);
  assign go_left = key < rdata;

  always_comb begin
    lo_c = lo;
    hb_c = hb;
    if (cmd.step) begin
      if (go_left) begin
        hb_c = mid_r;
      end else begin
        lo_c = mid_r + BW'(1);
      end
    end
  end

  assign sum_c        = (BW + 1)'(lo_c) + (BW + 1)'(hb_c) - (BW + 1)'(1);
  assign mid_c        = BW'(sum_c >> 1);
  assign status.more  = lo_c < hb_c;
  assign status.lo_nz = lo_c != '0;
  assign raddr        = status.more ? AW'(mid_c) : AW'(lo_c - BW'(1));
  assign hit          = rdata == key;

  stbs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo  <= '0;
      hb  <= n_sat;
      key <= item_value;
    end else if (cmd.step) begin
      lo <= lo_c;
      hb <= hb_c;
    end
    if (cmd.fin) begin
      res_found <= hit;
      res_pos   <= hit ? POS_W'(lo - BW'(1)) : '0;
    end else if (cmd.clr_res) begin
      res_found <= 1'b0;
      res_pos   <= '0;
    end
    if (cmd.out_load) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

endmodule

/* rtl/stbs_ctrl.sv */
module stbs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   req_type,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  stbs_pkg::stbs_status_t status,
  output stbs_pkg::stbs_cmd_t    cmd
);
  import stbs_pkg::*;

  stbs_state_t state;
  stbs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (status.more) begin
          state_next = ST_STEP;
        end else begin
          cmd.clr_res = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.more) begin
          state_next = ST_STEP;
        end else if (status.lo_nz) begin
          state_next = ST_FINAL;
        end else begin
          cmd.clr_res = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_FINAL: begin
        cmd.fin    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sorted_table_binary_search.sv */
// Write word: accepted while idle; writes may follow back to back.
// Search word: ST_ISSUE, k ST_STEP steps, ST_FINAL (skipped when the final low bound is
// 0), ST_DONE; k <= clog2(min(entry_count, TABLE_DEPTH) + 1) halving steps, 11 at 1024.
// One table RAM read and one compare per step; next word taken once the search is back
// in ST_IDLE; a held output word stalls the input.
// Reset clears the controller, the output valid and entry_count; table contents
// are undefined until written.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // entry_index[9:0], item_value[41:10], zero pad
  input  logic [0:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found[0], position[10:1], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stbs_pkg::*;

  logic [COUNT_W-1:0] entry_count;
  stbs_cmd_t          cmd;
  stbs_status_t       status;
  logic               found;
  logic [POS_W-1:0]   position;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? 32'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  stbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .req_type(s_tuser[0]),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .entry_count(entry_count),
    .entry_index(s_tdata[9:0]),
    .item_value (s_tdata[41:10]),
    .found      (found),
    .position   (position)
  );

  assign m_tdata = {5'b0, position, found};

endmodule
